[rtl/core/rtpd_pkg.sv]
// Shared types, constants and helper functions of the ring track phase detector.
package rtpd_pkg;

	localparam int CNT_W     = 8;
	localparam int THR_W     = 8;
	localparam int PHASE_W   = 3;
	localparam int NUM_REGS  = 7;
	localparam int REG_IDX_W = $clog2(NUM_REGS);

	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

	typedef enum logic [PHASE_W-1:0] {
		PH_NORMAL = 3'd0,
		PH_BEGIN  = 3'd1,
		PH_IN     = 3'd2,
		PH_RUN    = 3'd3,
		PH_OUT    = 3'd4,
		PH_END    = 3'd5
	} phase_t;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_BEGIN_THR  = 3'd0,
		REG_ENTER_THR  = 3'd1,
		REG_RUN_THR    = 3'd2,
		REG_DWELL_THR  = 3'd3,
		REG_EXIT_THR   = 3'd4,
		REG_FINISH_THR = 3'd5,
		REG_NORMAL_THR = 3'd6
	} reg_idx_t;

	localparam logic [THR_W-1:0] BEGIN_THR_RST  = 8'd10;
	localparam logic [THR_W-1:0] ENTER_THR_RST  = 8'd15;
	localparam logic [THR_W-1:0] RUN_THR_RST    = 8'd3;
	localparam logic [THR_W-1:0] DWELL_THR_RST  = 8'd15;
	localparam logic [THR_W-1:0] EXIT_THR_RST   = 8'd5;
	localparam logic [THR_W-1:0] FINISH_THR_RST = 8'd5;
	localparam logic [THR_W-1:0] NORMAL_THR_RST = 8'd8;

	// Threshold set handed from the register file to the phase logic.
	typedef struct packed {
		logic [THR_W-1:0] begin_thr;
		logic [THR_W-1:0] enter_thr;
		logic [THR_W-1:0] run_thr;
		logic [THR_W-1:0] dwell_thr;
		logic [THR_W-1:0] exit_thr;
		logic [THR_W-1:0] finish_thr;
		logic [THR_W-1:0] normal_thr;
	} thr_t;

	// One frame's lane observation.
	typedef struct packed {
		logic left_corner_valid;
		logic left_angle_negative;
		logic right_corner_valid;
		logic right_angle_positive;
		logic right_points_empty;
	} obs_t;

	// Saturating up or floored down step of a debounce counter.
	function automatic logic [CNT_W-1:0] cnt_step(input logic [CNT_W-1:0] c, input logic up);
		logic [CNT_W-1:0] r;
		if (up) begin
			r = (c == CNT_MAX) ? c : c + CNT_W'(1);
		end else begin
			r = (c == '0) ? c : c - CNT_W'(1);
		end
		return r;
	endfunction

endpackage

[rtl/core/rtpd_if.sv]
// Channel interfaces of the ring track phase detector: observations, results, register writes.
interface rtpd_obs_if;
	logic valid;
	logic ready;
	logic left_corner_valid;
	logic left_angle_negative;
	logic right_corner_valid;
	logic right_angle_positive;
	logic right_points_empty;

	modport source (
		output valid, left_corner_valid, left_angle_negative, right_corner_valid,
		       right_angle_positive, right_points_empty,
		input  ready
	);
	modport sink (
		input  valid, left_corner_valid, left_angle_negative, right_corner_valid,
		       right_angle_positive, right_points_empty,
		output ready
	);
endinterface

interface rtpd_res_if;
	logic                          valid;
	logic                          ready;
	logic [rtpd_pkg::PHASE_W-1:0] phase;
	logic                          phase_changed;

	modport source (output valid, phase, phase_changed, input ready);
	modport sink (input valid, phase, phase_changed, output ready);
endinterface

interface rtpd_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [rtpd_pkg::REG_IDX_W-1:0] index;
	logic [rtpd_pkg::THR_W-1:0]     data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

[rtl/core/rtpd_cfg_regs.sv]
// Threshold register file written through the configuration channel.
module rtpd_cfg_regs (
	input  logic            clk,
	input  logic            arst_n,
	rtpd_cfg_if.sink        cfg,
	output rtpd_pkg::thr_t  thr
);
	import rtpd_pkg::*;

	thr_t thr_q;

	assign cfg.ready = 1'b1;
	assign thr       = thr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q.begin_thr  <= BEGIN_THR_RST;
			thr_q.enter_thr  <= ENTER_THR_RST;
			thr_q.run_thr    <= RUN_THR_RST;
			thr_q.dwell_thr  <= DWELL_THR_RST;
			thr_q.exit_thr   <= EXIT_THR_RST;
			thr_q.finish_thr <= FINISH_THR_RST;
			thr_q.normal_thr <= NORMAL_THR_RST;
		end else if (cfg.valid) begin
			unique case (reg_idx_t'(cfg.index))
				REG_BEGIN_THR:  thr_q.begin_thr  <= cfg.data;
				REG_ENTER_THR:  thr_q.enter_thr  <= cfg.data;
				REG_RUN_THR:    thr_q.run_thr    <= cfg.data;
				REG_DWELL_THR:  thr_q.dwell_thr  <= cfg.data;
				REG_EXIT_THR:   thr_q.exit_thr   <= cfg.data;
				REG_FINISH_THR: thr_q.finish_thr <= cfg.data;
				REG_NORMAL_THR: thr_q.normal_thr <= cfg.data;
				default: ; // Writes past the last register are dropped.
			endcase
		end
	end
endmodule

[rtl/core/rtpd_in_stage.sv]
// Input register stage that captures one observation request.
module rtpd_in_stage (
	input  logic           clk,
	input  logic           arst_n,
	rtpd_obs_if.sink       obs,
	input  logic           take_s1,
	output logic           valid_s1,
	output rtpd_pkg::obs_t obs_s1
);
	import rtpd_pkg::*;

	logic valid_q;
	obs_t obs_q;

	// The stage refills in the same cycle it drains.
	assign obs.ready = !valid_q || take_s1;
	assign valid_s1  = valid_q;
	assign obs_s1    = obs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (obs.ready) begin
			valid_q <= obs.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (obs.valid && obs.ready) begin
			obs_q.left_corner_valid    <= obs.left_corner_valid;
			obs_q.left_angle_negative  <= obs.left_angle_negative;
			obs_q.right_corner_valid   <= obs.right_corner_valid;
			obs_q.right_angle_positive <= obs.right_angle_positive;
			obs_q.right_points_empty   <= obs.right_points_empty;
		end
	end
endmodule

[rtl/core/rtpd_phase_fsm.sv]
// Phase state machine with debounce and dwell counters, and the result register.
module rtpd_phase_fsm (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           valid_s1,
	input  rtpd_pkg::obs_t obs_s1,
	input  rtpd_pkg::thr_t thr,
	output logic           take_s1,
	rtpd_res_if.source     res
);
	import rtpd_pkg::*;

	phase_t           phase_q;
	logic [CNT_W-1:0] deb_q;
	logic [CNT_W-1:0] dwell_q;
	logic             res_valid_q;
	phase_t           res_phase_q;
	logic             res_changed_q;

	logic             lv, lneg, rv, rpos, rempty;
	logic             cond;
	logic [THR_W-1:0] cur_thr;
	phase_t           adv_phase;
	logic [CNT_W-1:0] deb_step;
	logic [CNT_W-1:0] dwell_step;
	phase_t           phase_d;
	logic [CNT_W-1:0] deb_d;
	logic [CNT_W-1:0] dwell_d;
	logic             changed_d;

	assign lv     = obs_s1.left_corner_valid;
	assign lneg   = obs_s1.left_angle_negative;
	assign rv     = obs_s1.right_corner_valid;
	assign rpos   = obs_s1.right_angle_positive;
	assign rempty = obs_s1.right_points_empty;

	assign take_s1 = valid_s1 && (!res_valid_q || res.ready);

	always_comb begin
		unique case (phase_q)
			PH_NORMAL: begin
				cond = !lv && rv && rpos;       cur_thr = thr.begin_thr;  adv_phase = PH_BEGIN;
			end
			PH_BEGIN: begin
				cond = !lv && (rempty || !rv);  cur_thr = thr.enter_thr;  adv_phase = PH_IN;
			end
			PH_IN: begin
				cond = lv && lneg && !rv;       cur_thr = thr.run_thr;    adv_phase = PH_RUN;
			end
			PH_RUN: begin
				cond = lv && lneg && !rv;       cur_thr = thr.exit_thr;   adv_phase = PH_OUT;
			end
			PH_OUT: begin
				cond = !lv;                     cur_thr = thr.finish_thr; adv_phase = PH_END;
			end
			PH_END: begin
				cond = !lv && !rv;              cur_thr = thr.normal_thr; adv_phase = PH_NORMAL;
			end
			default: begin
				cond = 1'b0;                    cur_thr = '0;             adv_phase = PH_NORMAL;
			end
		endcase
	end

	assign deb_step   = cnt_step(deb_q, cond);
	assign dwell_step = cnt_step(dwell_q, !lv && !rv);

	always_comb begin
		phase_d   = phase_q;
		deb_d     = deb_q;
		dwell_d   = dwell_q;
		changed_d = 1'b0;
		if (phase_q == PH_RUN) begin
			// Exit counting is held off until the dwell count is reached.
			dwell_d = dwell_step;
			if (dwell_step >= thr.dwell_thr) begin
				deb_d = deb_step;
				if (deb_step >= cur_thr) begin
					phase_d   = adv_phase;
					deb_d     = '0;
					dwell_d   = '0;
					changed_d = 1'b1;
				end
			end
		end else if (phase_q <= PH_END) begin
			deb_d = deb_step;
			if (deb_step >= cur_thr) begin
				phase_d   = adv_phase;
				deb_d     = '0;
				changed_d = 1'b1;
			end
		end else begin
			phase_d   = PH_NORMAL;
			deb_d     = '0;
			changed_d = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_NORMAL;
			deb_q       <= '0;
			dwell_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (take_s1) begin
				phase_q     <= phase_d;
				deb_q       <= deb_d;
				dwell_q     <= dwell_d;
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_s1) begin
			res_phase_q   <= phase_d;
			res_changed_q <= changed_d;
		end
	end

	assign res.valid         = res_valid_q;
	assign res.phase         = res_phase_q;
	assign res.phase_changed = res_changed_q;
endmodule

[rtl/core/ring_track_phase_detector.sv]
// Top level of the ring track phase detector.
//
// The block takes one lane observation per request on the obs channel and
// returns exactly one result per observation on the res channel: the phase
// of the roundabout state machine after that frame (normal, begin, in, run,
// out, end) and a flag that is set when that frame advanced the phase.
// Seven threshold registers are written through the cfg channel, which is
// always ready; a write to an index past the last register is dropped.
// Registers should only be written while no observation is in flight.
//
// An accepted observation passes into the input register, then through the
// phase logic into the result register. Throughput is one observation per
// cycle while the receiver takes results; the phase and counter update is a
// single pass of short logic. When the receiver stalls, the result register
// holds its value and the input register, if it is empty, still takes one
// more observation, after which obs.ready drops until the result is taken.
//
// Reset puts the machine in the normal phase with both counters cleared,
// empties both stages, and loads the threshold registers with their
// default values.
module ring_track_phase_detector (
	input logic      clk,
	input logic      arst_n,
	rtpd_obs_if.sink obs,
	rtpd_res_if.source res,
	rtpd_cfg_if.sink cfg
);
	import rtpd_pkg::*;

	thr_t thr;
	logic valid_s1;
	obs_t obs_s1;
	logic take_s1;

	// Threshold registers.
	rtpd_cfg_regs u_cfg_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.thr    (thr)
	);

	// Input register for one observation request.
	rtpd_in_stage u_in_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.obs      (obs),
		.take_s1  (take_s1),
		.valid_s1 (valid_s1),
		.obs_s1   (obs_s1)
	);

	// Phase machine, counters and result register.
	rtpd_phase_fsm u_phase_fsm (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.obs_s1   (obs_s1),
		.thr      (thr),
		.take_s1  (take_s1),
		.res      (res)
	);
endmodule

[rtl/core/rtpd_checker.sv]
// Port-level assertions for the ring track phase detector and their binding.
module rtpd_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          obs_valid,
	input logic                          obs_ready,
	input logic                          res_valid,
	input logic                          res_ready,
	input logic [rtpd_pkg::PHASE_W-1:0] res_phase,
	input logic                          res_phase_changed
);
	import rtpd_pkg::*;

	logic [1:0]         pend_q;
	logic [PHASE_W-1:0] last_q;
	logic [PHASE_W-1:0] succ;
	logic               obs_fire;
	logic               res_fire;

	assign obs_fire = obs_valid && obs_ready;
	assign res_fire = res_valid && res_ready;
	assign succ     = (last_q == PH_END) ? PH_NORMAL : last_q + PHASE_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
			last_q <= PH_NORMAL;
		end else begin
			if (obs_fire && !res_fire) begin
				pend_q <= pend_q + 2'd1;
			end else if (res_fire && !obs_fire) begin
				pend_q <= pend_q - 2'd1;
			end
			if (res_fire) begin
				last_q <= res_phase;
			end
		end
	end

	// At most two observations are ever held inside the block.
	a_pending_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q != 2'd3)
		else $error("more than two observations in flight");

	// A result is never shown without an observation to answer.
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> pend_q != 2'd0)
		else $error("result shown with nothing in flight");

	// A stalled result holds.
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_phase)
		&& $stable(res_phase_changed))
		else $error("stalled result changed");

	// An unchanged result repeats the previous phase; a change steps it once.
	a_phase_seq: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res_phase_changed ? (res_phase == succ) : (res_phase == last_q)))
		else $error("phase sequence broken");
endmodule

bind ring_track_phase_detector rtpd_checker u_rtpd_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.obs_valid         (obs.valid),
	.obs_ready         (obs.ready),
	.res_valid         (res.valid),
	.res_ready         (res.ready),
	.res_phase         (res.phase),
	.res_phase_changed (res.phase_changed)
);

[tb/rtpd_scoreboard.sv]
// Checker of the ring track phase detector: tracks the register writes, predicts each result and compares.
`timescale 1ns / 1ps

module rtpd_scoreboard
	import rtpd_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 obs_valid,
	input  logic                 obs_ready,
	input  obs_t                 obs_frame,
	input  logic                 res_valid,
	input  logic                 res_ready,
	input  logic [PHASE_W-1:0]   res_phase,
	input  logic                 res_changed,
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [REG_IDX_W-1:0] cfg_index,
	input  logic [THR_W-1:0]     cfg_data,
	output int                   mismatch_count,
	output int                   pending
);

	typedef struct packed {
		logic [PHASE_W-1:0] phase;
		logic               changed;
	} ring_result_t;

	// Predicted machine state and the thresholds as last written.
	phase_t           phase_now;
	logic [CNT_W-1:0] debounce;
	logic [CNT_W-1:0] dwell;
	thr_t             limits;

	ring_result_t expected_results[$];
	ring_result_t fresh;
	ring_result_t oldest;
	int           tally;

	function automatic logic [CNT_W-1:0] counter_nudge(input logic [CNT_W-1:0] c, input logic up);
		if (up)
			return (c == CNT_MAX) ? c : c + CNT_W'(1);
		return (c == '0) ? c : c - CNT_W'(1);
	endfunction

	// Applies one frame to the predicted machine and returns the result it should produce.
	task automatic step_ring(input obs_t f, output ring_result_t r);
		logic             lv, lneg, rv, rpos, rempty;
		logic             hit, gate;
		logic [THR_W-1:0] need;
		phase_t           after;
		lv     = f.left_corner_valid;
		lneg   = f.left_angle_negative;
		rv     = f.right_corner_valid;
		rpos   = f.right_angle_positive;
		rempty = f.right_points_empty;
		case (phase_now)
			PH_NORMAL: begin
				hit = !lv && rv && rpos;     need = limits.begin_thr;  after = PH_BEGIN;
			end
			PH_BEGIN: begin
				hit = !lv && (rempty || !rv); need = limits.enter_thr; after = PH_IN;
			end
			PH_IN: begin
				hit = lv && lneg && !rv;     need = limits.run_thr;    after = PH_RUN;
			end
			PH_RUN: begin
				hit = lv && lneg && !rv;     need = limits.exit_thr;   after = PH_OUT;
			end
			PH_OUT: begin
				hit = !lv;                   need = limits.finish_thr; after = PH_END;
			end
			PH_END: begin
				hit = !lv && !rv;            need = limits.normal_thr; after = PH_NORMAL;
			end
			// An illegal code has a zero threshold, so it falls back to normal at once.
			default: begin
				hit = 1'b0;                  need = '0;                after = PH_NORMAL;
			end
		endcase
		gate = 1'b1;
		if (phase_now == PH_RUN) begin
			dwell = counter_nudge(dwell, !lv && !rv);
			gate  = (dwell >= limits.dwell_thr);
		end
		r.changed = 1'b0;
		if (gate) begin
			debounce = counter_nudge(debounce, hit);
			if (debounce >= need) begin
				phase_now = after;
				debounce  = '0;
				dwell     = '0;
				r.changed = 1'b1;
			end
		end
		r.phase = phase_now;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_now = PH_NORMAL;
			debounce  = '0;
			dwell     = '0;
			limits    = '{BEGIN_THR_RST, ENTER_THR_RST, RUN_THR_RST, DWELL_THR_RST,
			              EXIT_THR_RST, FINISH_THR_RST, NORMAL_THR_RST};
			expected_results.delete();
			tally = 0;
			mismatch_count <= 0;
			pending        <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_BEGIN_THR:  limits.begin_thr  = cfg_data;
					REG_ENTER_THR:  limits.enter_thr  = cfg_data;
					REG_RUN_THR:    limits.run_thr    = cfg_data;
					REG_DWELL_THR:  limits.dwell_thr  = cfg_data;
					REG_EXIT_THR:   limits.exit_thr   = cfg_data;
					REG_FINISH_THR: limits.finish_thr = cfg_data;
					REG_NORMAL_THR: limits.normal_thr = cfg_data;
					default: ;
				endcase
			end
			if (obs_valid && obs_ready) begin
				step_ring(obs_frame, fresh);
				expected_results.push_back(fresh);
			end
			if (res_valid && res_ready) begin
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected result, phase %0d changed %0b",
						$time, res_phase, res_changed);
					tally++;
				end else begin
					oldest = expected_results.pop_front();
					if (res_phase !== oldest.phase) begin
						$display("%0t: phase expected %0d, actual %0d",
							$time, oldest.phase, res_phase);
						tally++;
					end
					if (res_changed !== oldest.changed) begin
						$display("%0t: phase_changed expected %0b, actual %0b",
							$time, oldest.changed, res_changed);
						tally++;
					end
				end
			end
			mismatch_count <= tally;
			pending        <= expected_results.size();
		end
	end

endmodule

[tb/ring_track_phase_detector_test.sv]
// Top of the ring track phase detector testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module ring_track_phase_detector_test
	import rtpd_pkg::*;
();

	// The run ends with a failure if it has not finished within this many cycles.
	localparam int CYCLE_LIMIT = 100000;
	// Number of random frames after the directed part.
	localparam int RANDOM_FRAMES = 100;
	// A register index one past the last register; writes to it must be dropped.
	localparam logic [REG_IDX_W-1:0] REG_PAST_END = REG_IDX_W'(NUM_REGS);
	localparam int OBS_W = $bits(obs_t);

	// Which phase condition a shaped frame is meant to satisfy.
	typedef enum {
		AIM_START,
		AIM_ENTRY,
		AIM_INSIDE,
		AIM_DWELL,
		AIM_EXIT,
		AIM_LEAVE,
		AIM_CLEAR
	} aim_e;

	logic clk;
	logic arst_n;
	int   mismatch_count;
	int   pending;
	int   sent_frames;
	int   cycles;
	int   random_start;
	int   hold_left;
	bit   held;

	// The stimulus keeps its own copy of the thresholds so that it can size the
	// frame runs that walk the machine around the ring.
	logic [THR_W-1:0] limits [NUM_REGS];

	rtpd_obs_if obs ();
	rtpd_res_if res ();
	rtpd_cfg_if cfg ();

	ring_track_phase_detector u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.obs    (obs),
		.res    (res),
		.cfg    (cfg)
	);

	rtpd_scoreboard u_scoreboard (
		.clk            (clk),
		.arst_n         (arst_n),
		.obs_valid      (obs.valid),
		.obs_ready      (obs.ready),
		.obs_frame      ({obs.left_corner_valid, obs.left_angle_negative,
		                  obs.right_corner_valid, obs.right_angle_positive,
		                  obs.right_points_empty}),
		.res_valid      (res.valid),
		.res_ready      (res.ready),
		.res_phase      (res.phase),
		.res_changed    (res.phase_changed),
		.cfg_valid      (cfg.valid),
		.cfg_ready      (cfg.ready),
		.cfg_index      (cfg.index),
		.cfg_data       (cfg.data),
		.mismatch_count (mismatch_count),
		.pending        (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog: a hung handshake or a lost result ends the run here.
	initial begin
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("Mismatches found");
		$finish;
	end

	// During this window of frames neither side idles, so the block runs at full rate.
	function automatic bit steady_window();
		return sent_frames >= 200 && sent_frames < 320;
	endfunction

	// Result receiver. It is ready about 73 percent of the time, except in the steady
	// window, and once it holds off for a long stretch so that the block fills
	// up and has to stall the observation side.
	always @(posedge clk) begin
		if (!arst_n) begin
			res.ready <= 1'b0;
			hold_left <= 0;
			held      <= 1'b0;
		end else if (hold_left > 0) begin
			res.ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (!held && sent_frames >= 120) begin
			held      <= 1'b1;
			hold_left <= 60;
			res.ready <= 1'b0;
		end else begin
			res.ready <= steady_window() || ($urandom_range(0, 99) >= 27);
		end
	end

	// Offers one frame, with a random number of idle cycles in front of it, and
	// returns at the edge where the request is taken. The valid stays high so
	// that back to back frames need no second assignment in the same step.
	task automatic send_frame(input obs_t f);
		while (!steady_window() && $urandom_range(0, 99) < 27) begin
			obs.valid <= 1'b0;
			@(posedge clk);
		end
		obs.valid                <= 1'b1;
		obs.left_corner_valid    <= f.left_corner_valid;
		obs.left_angle_negative  <= f.left_angle_negative;
		obs.right_corner_valid   <= f.right_corner_valid;
		obs.right_angle_positive <= f.right_angle_positive;
		obs.right_points_empty   <= f.right_points_empty;
		do @(posedge clk); while (!obs.ready);
		sent_frames++;
	endtask

	// A frame with random content, with the bits forced that make the chosen
	// phase condition true. The other bits stay random so every bit toggles.
	function automatic obs_t shape_frame(input aim_e aim);
		obs_t f;
		f = obs_t'(OBS_W'($urandom_range(0, 31)));
		case (aim)
			AIM_START: begin
				f.left_corner_valid    = 1'b0;
				f.right_corner_valid   = 1'b1;
				f.right_angle_positive = 1'b1;
			end
			AIM_ENTRY: begin
				// Either the right corner is gone or the right lane has no points.
				f.left_corner_valid = 1'b0;
				if (f.right_corner_valid)
					f.right_points_empty = 1'b1;
			end
			AIM_INSIDE, AIM_EXIT: begin
				f.left_corner_valid   = 1'b1;
				f.left_angle_negative = 1'b1;
				f.right_corner_valid  = 1'b0;
			end
			AIM_DWELL, AIM_CLEAR: begin
				f.left_corner_valid  = 1'b0;
				f.right_corner_valid = 1'b0;
			end
			AIM_LEAVE: f.left_corner_valid = 1'b0;
			default: ;
		endcase
		return f;
	endfunction

	// Sends a run of frames aimed at one phase; noise_pct of them are fully random.
	task automatic drive_segment(input aim_e aim, input int count, input int noise_pct);
		repeat (count) begin
			if ($urandom_range(0, 99) < noise_pct)
				send_frame(obs_t'(OBS_W'($urandom_range(0, 31))));
			else
				send_frame(shape_frame(aim));
		end
	endtask

	// Length of a run: the threshold, some slack for the noise that pulls the
	// debounce counter down, and a small random overshoot into the next phase.
	function automatic int stretch(input int need, input int noise_pct);
		return need + need * noise_pct / 40 + $urandom_range(0, 2);
	endfunction

	// One trip around the ring: normal, begin, in, run, out, end and back.
	// The dwell run has to cover the exit count as well, since every exit frame
	// takes the dwell counter down again. A nonzero dwell_len overrides it.
	task automatic drive_ring_pass(input int noise_pct, input int dwell_len);
		int dwell_frames;
		dwell_frames = dwell_len;
		if (dwell_frames == 0)
			dwell_frames = stretch(int'(limits[REG_DWELL_THR]) + int'(limits[REG_EXIT_THR]),
				noise_pct);
		drive_segment(AIM_START, stretch(int'(limits[REG_BEGIN_THR]), noise_pct), noise_pct);
		drive_segment(AIM_ENTRY, stretch(int'(limits[REG_ENTER_THR]), noise_pct), noise_pct);
		drive_segment(AIM_INSIDE, stretch(int'(limits[REG_RUN_THR]), noise_pct), noise_pct);
		drive_segment(AIM_DWELL, dwell_frames, noise_pct);
		drive_segment(AIM_EXIT, stretch(int'(limits[REG_EXIT_THR]), noise_pct), noise_pct);
		drive_segment(AIM_LEAVE, stretch(int'(limits[REG_FINISH_THR]), noise_pct), noise_pct);
		drive_segment(AIM_CLEAR, stretch(int'(limits[REG_NORMAL_THR]), noise_pct), noise_pct);
	endtask

	// Stops offering frames and waits until every result is back, plus a margin
	// for the two-stage pipeline to go quiet.
	task automatic settle();
		obs.valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (4) @(posedge clk);
	endtask

	// Writes all seven thresholds from the local copy, then a random value to
	// the index past the last register, which the block has to drop.
	task automatic load_limits();
		reg_idx_t r;
		r = r.first();
		repeat (NUM_REGS) begin
			cfg.valid <= 1'b1;
			cfg.index <= r;
			cfg.data  <= limits[r];
			do @(posedge clk); while (!cfg.ready);
			r = r.next();
		end
		cfg.valid <= 1'b1;
		cfg.index <= REG_PAST_END;
		cfg.data  <= THR_W'($urandom_range(0, 255));
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 1'b0;
	endtask

	// Mostly small thresholds so the ring turns over often, with an occasional
	// zero (advance on the first frame) and an occasional longer one.
	function automatic logic [THR_W-1:0] random_limit();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 8)
			return '0;
		if (roll < 14)
			return THR_W'($urandom_range(7, 24));
		return THR_W'($urandom_range(1, 5));
	endfunction

	task automatic set_all_limits(input logic [THR_W-1:0] value);
		foreach (limits[i])
			limits[i] = value;
	endtask

	initial begin
		arst_n                   <= 1'b0;
		obs.valid                <= 1'b0;
		obs.left_corner_valid    <= 1'b0;
		obs.left_angle_negative  <= 1'b0;
		obs.right_corner_valid   <= 1'b0;
		obs.right_angle_positive <= 1'b0;
		obs.right_points_empty   <= 1'b0;
		cfg.valid                <= 1'b0;
		cfg.index                <= REG_BEGIN_THR;
		cfg.data                 <= '0;
		sent_frames = 0;
		limits[REG_BEGIN_THR]  = BEGIN_THR_RST;
		limits[REG_ENTER_THR]  = ENTER_THR_RST;
		limits[REG_RUN_THR]    = RUN_THR_RST;
		limits[REG_DWELL_THR]  = DWELL_THR_RST;
		limits[REG_EXIT_THR]   = EXIT_THR_RST;
		limits[REG_FINISH_THR] = FINISH_THR_RST;
		limits[REG_NORMAL_THR] = NORMAL_THR_RST;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed frames at the reset thresholds: all bits low, all bits high,
		// each bit alone and each bit missing.
		send_frame('0);
		send_frame('1);
		for (int i = 0; i < OBS_W; i++) begin
			send_frame(obs_t'(OBS_W'(1) << i));
			send_frame(obs_t'(~(OBS_W'(1) << i)));
		end
		// Enough clean normal-phase frames to reach the default begin threshold.
		drive_segment(AIM_START, 11, 0);

		// Every threshold at one: each phase advances on its first good frame
		// and the dwell gate opens after a single quiet frame.
		settle();
		set_all_limits(THR_W'(1));
		load_limits();
		repeat (3) drive_ring_pass(0, 0);

		// Every threshold at zero: the machine advances on every frame, whatever
		// the frame holds, and exit counting starts without any dwell.
		settle();
		set_all_limits('0);
		load_limits();
		drive_segment(AIM_START, 20, 100);
		drive_ring_pass(0, 0);

		// Random part: mostly well-formed trips around the ring with random
		// filler bits and some noise, broken up by bursts of pure noise. The
		// thresholds change every few trips.
		random_start = sent_frames;
		while (sent_frames - random_start < RANDOM_FRAMES) begin
			settle();
			foreach (limits[i])
				limits[i] = random_limit();
			load_limits();
			repeat (3) begin
				if ($urandom_range(0, 99) < 15)
					drive_segment(AIM_START, $urandom_range(5, 20), 100);
				else
					drive_ring_pass(12, 0);
			end
		end

		// Large dwell threshold. Two clean trips at threshold one bring the
		// machine back to normal first. Then the run phase sees 270 quiet frames
		// against a dwell threshold of 200: the dwell counter has to stick at its
		// top value, otherwise it would wrap below the threshold and the exit
		// would never be seen.
		settle();
		set_all_limits(THR_W'(1));
		load_limits();
		repeat (2) drive_ring_pass(0, 0);
		settle();
		limits[REG_DWELL_THR]  = THR_W'(200);
		limits[REG_EXIT_THR]   = THR_W'(3);
		load_limits();
		drive_ring_pass(0, 270);

		// Drain: everything offered has been taken, now wait for every result.
		settle();
		repeat (8) @(posedge clk);
		if (mismatch_count == 0 && pending == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

[filelist.f]
rtl/core/rtpd_pkg.sv
rtl/core/rtpd_if.sv
rtl/core/rtpd_cfg_regs.sv
rtl/core/rtpd_in_stage.sv
rtl/core/rtpd_phase_fsm.sv
rtl/core/ring_track_phase_detector.sv
rtl/core/rtpd_checker.sv
tb/rtpd_scoreboard.sv
tb/ring_track_phase_detector_test.sv
